@@ rtl/dlr_pkg.sv @@
package dlr_pkg;

    localparam int COORD_BITS  = 10;
    localparam int FRAC_BITS   = 16;
    localparam int CURSOR_BITS = COORD_BITS + FRAC_BITS;
    localparam int STEP_BITS   = FRAC_BITS + 2;
    localparam int QUOT_BITS   = FRAC_BITS + 1;
    localparam int COUNT_BITS  = COORD_BITS + 1;
    localparam int COLOUR_BITS = 32;
    localparam int CHAN_BITS   = 8;
    localparam int DIV_CNT_BITS = $clog2(QUOT_BITS + 1);

    localparam logic [CHAN_BITS-1:0] ALPHA_OPAQUE = 8'd255;

    typedef enum logic
    {
        KIND_LOAD = 1'b0,
        KIND_STEP = 1'b1
    } kind_t;

    // Classified item as it waits in the queue between the front and back parts.
    typedef struct packed
    {
        kind_t                   kind;
        logic [COORD_BITS-1:0]   start_x;
        logic [COORD_BITS-1:0]   start_y;
        logic [COORD_BITS-1:0]   mag_x;
        logic [COORD_BITS-1:0]   mag_y;
        logic                    neg_x;
        logic                    neg_y;
        logic [COORD_BITS-1:0]   steps;
        logic [COLOUR_BITS-1:0]  colour;
    } cmd_t;

endpackage

@@ rtl/dlr_front.sv @@
module dlr_front
    import dlr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  kind_t                 kind,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [CHAN_BITS-1:0]  red,
    input  logic [CHAN_BITS-1:0]  green,
    input  logic [CHAN_BITS-1:0]  blue,
    output cmd_t                  head,
    output logic                  head_valid,
    input  logic                  pop
);

    cmd_t             entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    cmd_t             classified;
    logic             push;
    logic             do_pop;

    // Work out the line's extent once, at entry, so the back part only divides.
    always_comb
    begin
        classified.kind    = kind;
        classified.start_x = start_x;
        classified.start_y = start_y;
        classified.neg_x   = end_x < start_x;
        classified.neg_y   = end_y < start_y;
        classified.mag_x   = classified.neg_x ? (start_x - end_x) : (end_x - start_x);
        classified.mag_y   = classified.neg_y ? (start_y - end_y) : (end_y - start_y);
        classified.steps   = (classified.mag_x > classified.mag_y) ? classified.mag_x
                                                                   : classified.mag_y;
        classified.colour  = {ALPHA_OPAQUE, blue, green, red};
    end

    assign in_ready   = count_reg != 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head       = entry_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

@@ rtl/dlr_div.sv @@
module dlr_div
    import dlr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] mag,
    input  logic [COORD_BITS-1:0] divisor,
    output logic                  done,
    output logic [QUOT_BITS-1:0]  quotient
);

    logic [COUNT_BITS-1:0]   rem_reg;
    logic [COUNT_BITS-1:0]   rem_next;
    logic [QUOT_BITS-1:0]    quot_reg;
    logic [QUOT_BITS-1:0]    quot_next;
    logic [COORD_BITS-1:0]   div_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [DIV_CNT_BITS-1:0] cnt_next;
    logic                    done_reg;
    logic                    done_next;
    logic                    busy;
    logic                    ge;
    logic [COUNT_BITS-1:0]   diff;

    // The magnitude never exceeds the divisor, so the quotient has only
    // FRAC_BITS+1 bits and the partial remainder starts as the magnitude itself.
    assign busy = cnt_reg != '0;
    assign ge   = rem_reg >= {1'b0, div_reg};
    assign diff = ge ? (rem_reg - {1'b0, div_reg}) : rem_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {1'b0, mag};
            quot_next = '0;
            cnt_next  = DIV_CNT_BITS'(QUOT_BITS);
        end
        else if (busy)
        begin
            rem_next  = {diff[COUNT_BITS-2:0], 1'b0};
            quot_next = {quot_reg[QUOT_BITS-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = cnt_reg == DIV_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

@@ rtl/dlr_back.sv @@
module dlr_back
    import dlr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   head,
    input  logic                   head_valid,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_BITS-1:0]  pixel_x,
    output logic [COORD_BITS-1:0]  pixel_y,
    output logic [COLOUR_BITS-1:0] colour_code,
    output logic                   last
);

    typedef enum logic [1:0]
    {
        ST_RUN = 2'b01,
        ST_DIV = 2'b10
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [CURSOR_BITS-1:0]  cursor_x_reg;
    logic [CURSOR_BITS-1:0]  cursor_x_next;
    logic [CURSOR_BITS-1:0]  cursor_y_reg;
    logic [CURSOR_BITS-1:0]  cursor_y_next;
    logic [STEP_BITS-1:0]    step_x_reg;
    logic [STEP_BITS-1:0]    step_x_next;
    logic [STEP_BITS-1:0]    step_y_reg;
    logic [STEP_BITS-1:0]    step_y_next;
    logic [COUNT_BITS-1:0]   left_reg;
    logic [COUNT_BITS-1:0]   left_next;
    logic [COLOUR_BITS-1:0]  colour_reg;
    logic [COLOUR_BITS-1:0]  colour_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [COORD_BITS-1:0]   pixel_x_reg;
    logic [COORD_BITS-1:0]   pixel_x_next;
    logic [COORD_BITS-1:0]   pixel_y_reg;
    logic [COORD_BITS-1:0]   pixel_y_next;
    logic [COLOUR_BITS-1:0]  out_colour_reg;
    logic [COLOUR_BITS-1:0]  out_colour_next;
    logic                    last_reg;
    logic                    last_next;
    logic                    div_start;
    logic                    div_done;
    logic                    div_done_y;
    logic [QUOT_BITS-1:0]    quot_x;
    logic [QUOT_BITS-1:0]    quot_y;
    logic [STEP_BITS-1:0]    inc_x;
    logic [STEP_BITS-1:0]    inc_y;
    logic                    out_free;

    dlr_div u_div_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .mag      (head.mag_x),
        .divisor  (head.steps),
        .done     (div_done),
        .quotient (quot_x)
    );

    dlr_div u_div_y
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .mag      (head.mag_y),
        .divisor  (head.steps),
        .done     (div_done_y),
        .quotient (quot_y)
    );

    // A zero-length line must not use the quotient of a division by zero.
    always_comb
    begin
        if (head.steps == '0)
        begin
            inc_x = '0;
            inc_y = '0;
        end
        else
        begin
            inc_x = head.neg_x ? -{1'b0, quot_x} : {1'b0, quot_x};
            inc_y = head.neg_y ? -{1'b0, quot_y} : {1'b0, quot_y};
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        step_x_next     = step_x_reg;
        step_y_next     = step_y_reg;
        left_next       = left_reg;
        colour_next     = colour_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        pixel_x_next    = pixel_x_reg;
        pixel_y_next    = pixel_y_reg;
        out_colour_next = out_colour_reg;
        last_next       = last_reg;
        div_start       = 1'b0;
        pop             = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                if (head_valid && head.kind == KIND_LOAD)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else if (head_valid && left_reg == '0)
                begin
                    // A pixel request past the end of the line is dropped.
                    pop = 1'b1;
                end
                else if (head_valid && out_free)
                begin
                    pop             = 1'b1;
                    out_valid_next  = 1'b1;
                    pixel_x_next    = cursor_x_reg[CURSOR_BITS-1:FRAC_BITS]
                                    + {{(COORD_BITS-1){1'b0}}, cursor_x_reg[FRAC_BITS-1]};
                    pixel_y_next    = cursor_y_reg[CURSOR_BITS-1:FRAC_BITS]
                                    + {{(COORD_BITS-1){1'b0}}, cursor_y_reg[FRAC_BITS-1]};
                    out_colour_next = colour_reg;
                    last_next       = left_reg == COUNT_BITS'(1);
                    cursor_x_next   = cursor_x_reg
                                    + {{(CURSOR_BITS-STEP_BITS){step_x_reg[STEP_BITS-1]}},
                                       step_x_reg};
                    cursor_y_next   = cursor_y_reg
                                    + {{(CURSOR_BITS-STEP_BITS){step_y_reg[STEP_BITS-1]}},
                                       step_y_reg};
                    left_next       = left_reg - 1'b1;
                end
            end
            ST_DIV:
            begin
                // Both dividers start together and finish together.
                if (div_done && div_done_y)
                begin
                    pop           = 1'b1;
                    step_x_next   = inc_x;
                    step_y_next   = inc_y;
                    cursor_x_next = {head.start_x, {FRAC_BITS{1'b0}}};
                    cursor_y_next = {head.start_y, {FRAC_BITS{1'b0}}};
                    left_next     = {1'b0, head.steps};
                    colour_next   = head.colour;
                    state_next    = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            left_reg      <= '0;
            colour_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            step_x_reg    <= step_x_next;
            step_y_reg    <= step_y_next;
            left_reg      <= left_next;
            colour_reg    <= colour_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg    <= pixel_x_next;
        pixel_y_reg    <= pixel_y_next;
        out_colour_reg <= out_colour_next;
        last_reg       <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign colour_code = out_colour_reg;
    assign last        = last_reg;

endmodule

@@ rtl/dda_line_rasterizer.sv @@
// DDA line rasterizer.
// Input stream (s_axis_*): tuser is the item kind, 0 loads a line, 1 asks for
// the next pixel. On a load, tdata carries both endpoints and the RGB colour.
// Output stream (m_axis_*): one item per pixel request while the line still
// has pixels: the rounded cursor position, the packed ABGR colour and tlast
// on the final pixel. The end point itself is never drawn; requests past the
// end, or with no line loaded, give no output item.
// Input items enter a two-entry queue, so the input side can go on taking items
// while a load is being worked on or the output side stalls, until it is full.
// A pixel request passes through the queue entry and then the output register
// before its item appears on the output. Pixel requests sustain one item per
// cycle while m_axis_tready stays high. A load occupies the back end while the
// two bit-serial increment dividers run side by side.
// When the receiver holds m_axis_tready low, the output register holds its
// item, the back end stops at the next pixel request, and the queue fills and
// then drops s_axis_tready.
// Reset clears the cursors, increments, pixel count and colour, so requests
// before the first load give nothing.
module dda_line_rasterizer
    import dlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // start_x[9:0], start_y[19:10], end_x[29:20], end_y[39:30],
    // red[47:40], green[55:48], blue[63:56]
    input  logic [63:0] s_axis_tdata,
    // kind[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_x[9:0], pixel_y[19:10], colour_code[51:20], zero fill [55:52]
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    cmd_t                   head;
    logic                   head_valid;
    logic                   pop;
    logic [COORD_BITS-1:0]  pixel_x;
    logic [COORD_BITS-1:0]  pixel_y;
    logic [COLOUR_BITS-1:0] colour_code;

    dlr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .kind       (kind_t'(s_axis_tuser)),
        .start_x    (s_axis_tdata[9:0]),
        .start_y    (s_axis_tdata[19:10]),
        .end_x      (s_axis_tdata[29:20]),
        .end_y      (s_axis_tdata[39:30]),
        .red        (s_axis_tdata[47:40]),
        .green      (s_axis_tdata[55:48]),
        .blue       (s_axis_tdata[63:56]),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    dlr_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .colour_code (colour_code),
        .last        (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, colour_code, pixel_y, pixel_x};

endmodule

@@ dv/tb_top.sv @@
module tb_top
    import dlr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS   = 1300;
    localparam int TAIL_CALM = 200;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        kind_t                 kind;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        logic [CHAN_BITS-1:0]  red;
        logic [CHAN_BITS-1:0]  green;
        logic [CHAN_BITS-1:0]  blue;
    } line_item_t;

    typedef struct {
        logic [COORD_BITS-1:0]  px;
        logic [COORD_BITS-1:0]  py;
        logic [COLOUR_BITS-1:0] colour;
        logic                   last;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;

    line_item_t pending_items[$];
    pixel_t     pixel_expect[$];
    int         mismatches = 0;

    // Shadow of the line generator.
    logic [CURSOR_BITS-1:0]       cur_x = '0;
    logic [CURSOR_BITS-1:0]       cur_y = '0;
    logic signed [STEP_BITS-1:0]  inc_x = '0;
    logic signed [STEP_BITS-1:0]  inc_y = '0;
    logic [COUNT_BITS-1:0]        pixels_left = '0;
    logic [COLOUR_BITS-1:0]       line_colour = '0;

    dda_line_rasterizer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic signed [STEP_BITS-1:0] line_increment(int diff, int steps);
        int mag;
        int q;
        if (steps <= 0)
            return '0;
        mag = (diff < 0) ? -diff : diff;
        q = (mag << FRAC_BITS) / steps;
        return STEP_BITS'((diff < 0) ? -q : q);
    endfunction

    function automatic logic [COORD_BITS-1:0] round_cursor(logic [CURSOR_BITS-1:0] c);
        logic [CURSOR_BITS:0] sum;
        sum = {1'b0, c} + (CURSOR_BITS+1)'(1 << (FRAC_BITS - 1));
        return sum[FRAC_BITS +: COORD_BITS];
    endfunction

    task automatic queue_item(input line_item_t it);
        pending_items = {pending_items, it};
    endtask

    task automatic expect_pixel(input pixel_t px);
        pixel_expect = {pixel_expect, px};
    endtask

    task automatic rasterize_item(input line_item_t it);
        int     dx;
        int     dy;
        int     ax;
        int     ay;
        int     steps;
        pixel_t px;
        if (it.kind == KIND_LOAD)
        begin
            dx = int'(it.ex) - int'(it.sx);
            dy = int'(it.ey) - int'(it.sy);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            steps = (ax > ay) ? ax : ay;
            inc_x = line_increment(dx, steps);
            inc_y = line_increment(dy, steps);
            cur_x = {it.sx, {FRAC_BITS{1'b0}}};
            cur_y = {it.sy, {FRAC_BITS{1'b0}}};
            pixels_left = COUNT_BITS'(steps);
            line_colour = {ALPHA_OPAQUE, it.blue, it.green, it.red};
        end
        else if (pixels_left != '0)
        begin
            px.px = round_cursor(cur_x);
            px.py = round_cursor(cur_y);
            px.colour = line_colour;
            px.last = (pixels_left == COUNT_BITS'(1));
            expect_pixel(px);
            cur_x = cur_x + CURSOR_BITS'(inc_x);
            cur_y = cur_y + CURSOR_BITS'(inc_y);
            pixels_left = pixels_left - COUNT_BITS'(1);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    function automatic line_item_t load_item(int sx, int sy, int ex, int ey,
                                             int r, int g, int b);
        line_item_t it;
        it.kind = KIND_LOAD;
        it.sx = COORD_BITS'(sx);
        it.sy = COORD_BITS'(sy);
        it.ex = COORD_BITS'(ex);
        it.ey = COORD_BITS'(ey);
        it.red = CHAN_BITS'(r);
        it.green = CHAN_BITS'(g);
        it.blue = CHAN_BITS'(b);
        return it;
    endfunction

    // Pixel requests carry random payload that the block has to ignore.
    function automatic line_item_t step_item();
        line_item_t it;
        it = load_item($urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255));
        it.kind = KIND_STEP;
        return it;
    endfunction

    task automatic add_steps(int n);
        repeat (n) queue_item(step_item());
    endtask

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
    endfunction

    // Driver: presents queued items and feeds the shadow model on acceptance.
    line_item_t drv_item;
    int         in_gap = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                rasterize_item(drv_item);
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // Hold the current item until it is taken.
            end
            else if (in_gap > 0)
            begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_items.size() > TAIL_CALM && $urandom_range(0, 9) == 0)
            begin
                in_gap = $urandom_range(1, 19) - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                drv_item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= drv_item.kind;
                s_axis_tdata <= {drv_item.blue, drv_item.green, drv_item.red,
                                 drv_item.ey, drv_item.ex, drv_item.sy, drv_item.sx};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: random back-pressure and in-order comparison of pixels.
    int     out_gap = 0;
    pixel_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pixel_expect.size() == 0)
                    report_mismatch("unexpected pixel", '0,
                                    64'({m_axis_tlast, m_axis_tdata}));
                else
                begin
                    want = pixel_expect.pop_front();
                    if (m_axis_tdata[9:0] !== want.px)
                        report_mismatch("pixel_x", 64'(want.px), 64'(m_axis_tdata[9:0]));
                    if (m_axis_tdata[19:10] !== want.py)
                        report_mismatch("pixel_y", 64'(want.py), 64'(m_axis_tdata[19:10]));
                    if (m_axis_tdata[51:20] !== want.colour)
                        report_mismatch("colour_code", 64'(want.colour),
                                        64'(m_axis_tdata[51:20]));
                    if (m_axis_tdata[55:52] !== 4'b0)
                        report_mismatch("zero fill", '0, 64'(m_axis_tdata[55:52]));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", 64'(want.last), 64'(m_axis_tlast));
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (pending_items.size() > TAIL_CALM && $urandom_range(0, 9) == 0)
            begin
                out_gap = $urandom_range(1, 19) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int mode;
        int sx;
        int sy;
        int ex;
        int ey;
        int len;

        // Request before any line is loaded.
        add_steps(1);
        // Diagonal from the origin, black, one request past the end.
        queue_item(load_item(0, 0, 3, 3, 0, 0, 0));
        add_steps(4);
        // Leftward from the top corner, white.
        queue_item(load_item(1023, 1023, 1020, 1023, 255, 255, 255));
        add_steps(3);
        // Equal endpoints draw nothing.
        queue_item(load_item(512, 512, 512, 512, 8'h12, 8'h34, 8'h56));
        add_steps(1);
        // Shallow line going up, abandoned by a new load.
        queue_item(load_item(0, 1023, 5, 1021, 8'hAA, 8'h55, 8'h0F));
        add_steps(2);
        // Full-span anti-diagonal, also abandoned.
        queue_item(load_item(1023, 0, 0, 1023, 8'h01, 8'h80, 8'hFE));
        add_steps(2);
        // Steep line with fractional increments.
        queue_item(load_item(10, 0, 13, 7, 8'h7F, 8'h00, 8'hC3));
        add_steps(3);

        while (pending_items.size() < N_ITEMS)
        begin
            mode = $urandom_range(0, 99);
            if (mode < 6)
                add_steps(1);
            else if (mode < 14)
            begin
                // Long line over the whole grid, cut short.
                queue_item(load_item(
                    $urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255)));
                add_steps($urandom_range(1, 30));
            end
            else
            begin
                sx = $urandom_range(0, 1023);
                sy = $urandom_range(0, 1023);
                ex = clamp_coord(sx + int'($urandom_range(0, 48)) - 24);
                ey = clamp_coord(sy + int'($urandom_range(0, 48)) - 24);
                queue_item(load_item(sx, sy, ex, ey,
                    $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255)));
                len = (ex > sx) ? ex - sx : sx - ex;
                if (((ey > sy) ? ey - sy : sy - ey) > len)
                    len = (ey > sy) ? ey - sy : sy - ey;
                if ($urandom_range(0, 7) == 0)
                    add_steps($urandom_range(0, len));
                else
                    add_steps(len + $urandom_range(0, 3));
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (pixel_expect.size() != 0)
            @(posedge clk);
        // A trailing load may still be in the dividers.
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
